// ===== hdl/gaesf_pkg.sv =====
// Package for the GIF application extension sub-block framer.
// Holds fixed header bytes, register indexes and the result-sequence kinds.
// No dependencies.
package gaesf_pkg;

    localparam logic [7:0] EXT_INTRODUCER = 8'h21;
    localparam logic [7:0] APP_LABEL      = 8'hFF;
    localparam logic [7:0] APP_BLOCK_SIZE = 8'h0B;
    localparam logic [7:0] BLOCK_TERM     = 8'h00;

    localparam int unsigned HDR_RESULTS      = 14;
    localparam int unsigned HDR_ZERO_RESULTS = 16;
    localparam int unsigned IDX_W            = 4;

    localparam logic [1:0] REG_IDENTIFIER = 2'd0;
    localparam logic [1:0] REG_AUTH       = 2'd1;
    localparam logic [1:0] REG_LENGTH     = 2'd2;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    typedef enum logic [2:0] {
        KIND_HDR  = 3'b001,
        KIND_ERR  = 3'b010,
        KIND_DATA = 3'b100
    } t_kind;

endpackage

// ===== hdl/gif_app_extension_subblock_framer_core.sv =====
// GIF application extension sub-block framer, top level.
// Depends on gaesf_pkg.
//
// Use: configure identifier, authentication code and payload length over the
// config channel (i_cfg_*), always ready, while the block is idle. Then send a
// start command (i_command = 0) followed by payload bytes (i_command = 1) on
// the input channel. The output channel gives one encoded byte per transfer;
// o_end_of_run marks the last byte caused by an input item and o_error_flag a
// payload byte that arrived with no run open.
// Latency: the first result of an item is valid the cycle after its transfer.
// Throughput: one result per cycle while the receiver is ready. A start gives
// 14 results (16 for a zero length); a payload byte gives 1, 2 where a
// sub-block length byte or the terminator is added, 3 where both are. The next
// item is taken in the same cycle as the last result of the current one, so
// plain payload bytes stream at one per cycle while the receiver is ready.
// Reset clears the run state and the configuration to zero; no results are
// pending. When the receiver stalls the current result holds and the input
// channel stays not ready until the last result of the item is transferred.
module gif_app_extension_subblock_framer_core #(
    parameter int unsigned MAX_CHUNK = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_payload_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_run,
    output logic        o_error_flag
);

    localparam int unsigned IW = gaesf_pkg::IDX_W;

    logic [63:0] r_ident;
    logic [23:0] r_auth;
    logic [23:0] r_length;

    logic        r_active, n_active;
    logic [23:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_chunk_left, n_chunk_left;

    logic              r_busy;
    gaesf_pkg::t_kind  r_kind, n_kind;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_last_idx, n_last_idx;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_pay;
    logic              r_has_len, n_has_len;

    logic in_xfer, out_xfer, out_last;
    logic [7:0] sub_len;
    logic [1:0] data_pos;
    logic [2:0] id_sel;
    logic [1:0] auth_sel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident  <= '0;
            r_auth   <= '0;
            r_length <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gaesf_pkg::REG_IDENTIFIER: r_ident  <= i_cfg_data;
                gaesf_pkg::REG_AUTH:       r_auth   <= i_cfg_data[23:0];
                gaesf_pkg::REG_LENGTH:     r_length <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign out_last   = (r_idx == r_last_idx);
    assign out_xfer   = o_out_valid & i_out_ready;
    assign o_in_ready = !r_busy || (i_out_ready && out_last);
    assign in_xfer    = i_in_valid & o_in_ready;

    assign sub_len = (r_bytes_left < 24'(MAX_CHUNK)) ? r_bytes_left[7:0] : 8'(MAX_CHUNK);

    // Run state and result sequence for the incoming item
    always_comb begin
        n_active     = r_active;
        n_bytes_left = r_bytes_left;
        n_chunk_left = r_chunk_left;
        n_kind       = gaesf_pkg::KIND_ERR;
        n_last_idx   = '0;
        n_len        = sub_len;
        n_has_len    = 1'b0;
        if (i_command == gaesf_pkg::CMD_START) begin
            n_kind       = gaesf_pkg::KIND_HDR;
            n_bytes_left = r_length;
            n_chunk_left = '0;
            n_active     = (r_length != '0);
            n_last_idx   = (r_length == '0) ? IW'(gaesf_pkg::HDR_ZERO_RESULTS - 1)
                                            : IW'(gaesf_pkg::HDR_RESULTS - 1);
        end else if (r_active && r_bytes_left != '0) begin
            n_kind       = gaesf_pkg::KIND_DATA;
            n_has_len    = (r_chunk_left == '0);
            n_bytes_left = r_bytes_left - 24'd1;
            n_chunk_left = (r_chunk_left == '0) ? sub_len - 8'd1 : r_chunk_left - 8'd1;
            if (r_bytes_left == 24'd1) begin
                n_active     = 1'b0;
                n_chunk_left = '0;
            end
            n_last_idx = IW'({1'b0, n_has_len}) + IW'({1'b0, r_bytes_left == 24'd1});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_bytes_left <= '0;
            r_chunk_left <= '0;
            r_busy       <= 1'b0;
            r_idx        <= '0;
            r_kind       <= gaesf_pkg::KIND_ERR;
            r_last_idx   <= '0;
        end else if (in_xfer) begin
            r_active     <= n_active;
            r_bytes_left <= n_bytes_left;
            r_chunk_left <= n_chunk_left;
            r_busy       <= 1'b1;
            r_idx        <= '0;
            r_kind       <= n_kind;
            r_last_idx   <= n_last_idx;
        end else if (out_xfer) begin
            if (out_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_len     <= n_len;
            r_pay     <= i_payload_byte;
            r_has_len <= n_has_len;
        end
    end

    assign id_sel   = 3'(r_idx - IW'(3));
    assign auth_sel = 2'(r_idx - IW'(11));
    assign data_pos = 2'(r_idx) + {1'b0, !r_has_len};

    always_comb begin
        o_out_byte   = gaesf_pkg::BLOCK_TERM;
        o_error_flag = 1'b0;
        case (r_kind)
            gaesf_pkg::KIND_HDR: begin
                case (r_idx) inside
                    IW'(0):           o_out_byte = gaesf_pkg::EXT_INTRODUCER;
                    IW'(1):           o_out_byte = gaesf_pkg::APP_LABEL;
                    IW'(2):           o_out_byte = gaesf_pkg::APP_BLOCK_SIZE;
                    [IW'(3):IW'(10)]: o_out_byte = r_ident[8*(7-id_sel) +: 8];
                    [IW'(11):IW'(13)]: o_out_byte = r_auth[8*(2-auth_sel) +: 8];
                    default:          o_out_byte = gaesf_pkg::BLOCK_TERM;
                endcase
            end
            gaesf_pkg::KIND_DATA: begin
                case (data_pos)
                    2'd0:    o_out_byte = r_len;
                    2'd1:    o_out_byte = r_pay;
                    default: o_out_byte = gaesf_pkg::BLOCK_TERM;
                endcase
            end
            default: o_error_flag = 1'b1;
        endcase
    end

    assign o_out_valid  = r_busy;
    assign o_end_of_run = out_last;

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_flag) |-> (o_end_of_run && o_out_byte == 8'd0))
        else $error("error result not a lone zero byte");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_last_idx))
        else $error("result index past end of sequence");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_busy && r_idx == '0))
        else $error("accepted item did not start a sequence");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !out_xfer) |-> !in_xfer)
        else $error("item accepted while results pending");

    a_run_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left == '0) |-> !r_active)
        else $error("run active with no bytes left");

endmodule

// ===== verif/gif_app_extension_subblock_framer_core_test.sv =====
// Self-checking testbench for gif_app_extension_subblock_framer_core.
// Drives start commands and payload bytes, predicts the encoded extension bytes
// and checks them against the output stream. Depends on gaesf_pkg.
`timescale 1ns / 1ps

module gif_app_extension_subblock_framer_core_test;

    localparam int unsigned CHUNK_MAX   = 255;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;
    localparam int          HOLD_CYCLES = 200;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          LONG_AT     = 4;
    localparam int          TAIL_ITEMS  = 4;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pb;
    } t_framer_item;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       err;
    } t_framed_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = gaesf_pkg::CMD_START;
    logic [7:0]  i_payload_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_end_of_run;
    logic        o_error_flag;

    gif_app_extension_subblock_framer_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_payload_byte (i_payload_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_end_of_run   (o_end_of_run),
        .o_error_flag   (o_error_flag)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow registers and run state
    logic [63:0] ident_reg = '0;
    logic [23:0] auth_reg = '0;
    logic [23:0] length_reg = '0;
    logic        run_open = 1'b0;
    logic [23:0] bytes_left = '0;
    logic [7:0]  chunk_left = '0;

    t_framer_item pending_items[$];
    t_framed_byte expected_bytes[$];
    int items_queued = 0;
    int items_taken = 0;
    int mismatches = 0;
    int hold_wanted = 0;
    int hold_served = 0;
    bit sender_idles = 1'b0;
    bit receiver_idles = 1'b0;

    task automatic encode_item(input logic cmd, input logic [7:0] pb);
        logic [7:0]   seq[$];
        logic         err;
        logic [23:0]  len;
        t_framed_byte fb;
        int           i;
        err = 1'b0;
        if (cmd == gaesf_pkg::CMD_START) begin
            seq = {seq, gaesf_pkg::EXT_INTRODUCER};
            seq = {seq, gaesf_pkg::APP_LABEL};
            seq = {seq, gaesf_pkg::APP_BLOCK_SIZE};
            for (i = 0; i < 8; i++) seq = {seq, ident_reg[63 - 8 * i -: 8]};
            for (i = 0; i < 3; i++) seq = {seq, auth_reg[23 - 8 * i -: 8]};
            bytes_left = length_reg;
            chunk_left = '0;
            if (length_reg == 0) begin
                seq = {seq, gaesf_pkg::BLOCK_TERM};
                seq = {seq, gaesf_pkg::BLOCK_TERM};
                run_open = 1'b0;
            end else begin
                run_open = 1'b1;
            end
        end else if (!run_open || bytes_left == 0) begin
            err = 1'b1;
            seq = {seq, 8'h00};
        end else begin
            if (chunk_left == 0) begin
                len = (bytes_left < 24'(CHUNK_MAX)) ? bytes_left : 24'(CHUNK_MAX);
                seq = {seq, len[7:0]};
                chunk_left = len[7:0];
            end
            seq = {seq, pb};
            chunk_left--;
            bytes_left--;
            if (bytes_left == 0) begin
                seq = {seq, gaesf_pkg::BLOCK_TERM};
                run_open = 1'b0;
                chunk_left = '0;
            end
        end
        foreach (seq[k]) begin
            fb.value = seq[k];
            fb.last  = (k == seq.size() - 1);
            fb.err   = err;
            expected_bytes = {expected_bytes, fb};
        end
    endtask

    // sender
    always @(posedge i_clk) begin : drive_proc
        logic         next_valid;
        t_framer_item nxt;
        int           gap_left;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                encode_item(i_command, i_payload_byte);
                items_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0) begin
                    if (sender_idles && $urandom_range(0, 9) == 0) begin
                        gap_left = $urandom_range(0, 11);
                    end else begin
                        nxt = pending_items.pop_front();
                        next_valid = 1'b1;
                        i_command <= nxt.cmd;
                        i_payload_byte <= nxt.pb;
                    end
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // receiver and checker
    always @(posedge i_clk) begin : collect_proc
        logic         next_ready;
        t_framed_byte want;
        int           stall_left;
        int           hold_left;
        if (!i_rst_n) begin
            next_ready = 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: byte %h last %b err %b",
                                 o_out_byte, o_end_of_run, o_error_flag);
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.value || o_end_of_run !== want.last ||
                        o_error_flag !== want.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp byte %h last %b err %b, got %h %b %b",
                                     want.value, want.last, want.err,
                                     o_out_byte, o_end_of_run, o_error_flag);
                    end
                end
            end
            if (hold_served != hold_wanted) begin
                hold_served = hold_wanted;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 11);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
        end
        i_out_ready <= next_ready;
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge i_clk) begin : watchdog_proc
        int quiet;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic cmd, input logic [7:0] pb);
        t_framer_item it;
        it.cmd = cmd;
        it.pb  = pb;
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            gaesf_pkg::REG_IDENTIFIER: ident_reg = val;
            gaesf_pkg::REG_AUTH:       auth_reg = val[23:0];
            gaesf_pkg::REG_LENGTH:     length_reg = val[23:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] ident, input logic [63:0] auth,
                             input logic [63:0] length);
        write_reg(gaesf_pkg::REG_IDENTIFIER, ident);
        write_reg(gaesf_pkg::REG_AUTH, auth);
        write_reg(gaesf_pkg::REG_LENGTH, length);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk); while (items_taken != items_queued || expected_bytes.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int          rand_items;
        int          tail_items;
        int          start_count;
        int          len;
        int          shape;
        int          n;
        int          i;
        bit          long_done;
        logic [63:0] word;
        rand_items = 0;
        tail_items = 0;
        long_done = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: stray byte, zero-length run
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'hA5);
        queue_item(gaesf_pkg::CMD_START, 8'h00);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'hFF);
        settle();

        // single-byte run, all-ones header
        write_reg(REG_UNUSED, {$urandom, $urandom});
        configure('1, '1, 64'd1);
        queue_item(gaesf_pkg::CMD_START, 8'hFF);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'h00);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'h7F);
        settle();

        // maximum length, abandoned by a restart
        configure({$urandom, $urandom}, {$urandom, $urandom}, '1);
        queue_item(gaesf_pkg::CMD_START, 8'h00);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'h80);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'h01);
        queue_item(gaesf_pkg::CMD_START, 8'h33);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'h55);
        settle();

        // two-byte runs with zero header fields
        configure('0, '0, 64'd2);
        queue_item(gaesf_pkg::CMD_START, 8'h00);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'hC3);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'h3C);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'h0F);
        queue_item(gaesf_pkg::CMD_START, 8'hF0);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'hAA);
        queue_item(gaesf_pkg::CMD_START, 8'h00);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'h5A);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'hA5);
        queue_item(gaesf_pkg::CMD_PAYLOAD, 8'h11);
        settle();

        // random runs with idling, one long run under a held receiver, then an idle-free tail
        while (!long_done || tail_items < TAIL_ITEMS) begin
            start_count = items_queued;
            sender_idles = !long_done && ($urandom_range(0, 2) != 0);
            receiver_idles = !long_done && ($urandom_range(0, 2) != 0);
            if (!long_done && rand_items >= LONG_AT) begin
                len = $urandom_range(CHUNK_MAX + 1, CHUNK_MAX + 3);
            end else if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(0, 12);
            end else begin
                len = $urandom_range(13, 24);
            end
            word = {$urandom, $urandom};
            word[23:0] = len[23:0];
            configure({$urandom, $urandom}, {$urandom, $urandom}, word);
            shape = (!long_done && len > CHUNK_MAX) ? 0 : $urandom_range(0, 9);
            queue_item(gaesf_pkg::CMD_START, 8'($urandom_range(0, 255)));
            n = (shape == 7) ? $urandom_range(0, len) : len;
            for (i = 0; i < n; i++)
                queue_item(gaesf_pkg::CMD_PAYLOAD, 8'($urandom_range(0, 255)));
            if (shape == 8) begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    queue_item(gaesf_pkg::CMD_PAYLOAD, 8'($urandom_range(0, 255)));
            end else if (shape == 9) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            if (long_done) begin
                tail_items += items_queued - start_count;
            end else begin
                rand_items += items_queued - start_count;
            end
            if (!long_done && len > CHUNK_MAX) begin
                long_done = 1'b1;
                hold_wanted++;
            end
            settle();
        end

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== gif_app_extension_subblock_framer_core.f =====
hdl/gaesf_pkg.sv
hdl/gif_app_extension_subblock_framer_core.sv
verif/gif_app_extension_subblock_framer_core_test.sv
